// ===== sv/rational_arithmetic_unit_defines.svh =====
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
// a condition implies a consequence on the same edge
`define RAU_ASSERT_IMPL(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("rau check failed");
// a condition implies a consequence on the next edge
`define RAU_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("rau check failed");
`endif

// ===== sv/rau_pkg.sv =====
// shared types and codes for the rational arithmetic unit
package rau_pkg;
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_GT  = 3'd4;
   localparam logic [2:0] OP_LT  = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SIGN, ST_MUL, ST_GCD1, ST_LCM, ST_TERMS, ST_COMB,
      ST_GCD2, ST_RED, ST_CHECK, ST_OUT
   } state_type;

   // divider command and status
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;
endpackage

// ===== sv/rau_divider.sv =====
// restoring radix-2 unsigned divider, one quotient bit per cycle
module rau_divider #(
   parameter int W = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rau_pkg::div_ctl_type  ctl,
   input  logic [W-1:0]          dividend,
   input  logic [W-1:0]          divisor,
   output rau_pkg::div_sts_type  sts,
   output logic [W-1:0]          quotient,
   output logic [W-1:0]          remainder
);
   import rau_pkg::*;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [W:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[W-1]} - {1'b0, d_ff};
      if (ctl.start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-2:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// rational arithmetic unit top level: sequencer around a shared divider
//  channel | dir | handshake         | payload
//  req     | in  | req_tvalid/tready | op, a_num, a_den, b_num, b_den
//  rsp     | out | rsp_tvalid/tready | result_num, result_den, compare_true, error
// each request runs alone; compares and errors caught at the sign step go straight to the output state
// divisions run one at a time on the shared divider: one per euclid step of the
// reduction gcd plus two reduction divisions, and for add and subtract also the euclid
// steps of the denominator gcd and three more
// reset is synchronous and clears the sequencer and the divider's busy, done and count registers only
// req_tready is low from acceptance until the response is taken
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // a_num, a_den, b_num, b_den (16 bits each)
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // result_num 32, result_den 31, zero bit
   output logic [1:0]  rsp_tuser   // compare_true, error
);
   import rau_pkg::*;
   localparam int W = 64;
   localparam int OW = OPERAND_WIDTH;

   state_type st_ff, st_in;
   logic [2:0] op_ff, op_in;
   logic signed [OW:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, n_ff, n_in, d_ff, d_in, t1_ff, t1_in;
   logic neg_ff, neg_in, err_ff, err_in;
   logic [1:0] sub_ff, sub_in;
   logic [31:0] onum_ff, onum_in;
   logic [30:0] oden_ff, oden_in;
   logic [W-1:0] dv_a, dv_b, dq, dr;
   div_ctl_type dctl;
   div_sts_type dsts;
   logic signed [2*OW+1:0] lhs, rhs;
   logic [OW-1:0] anm, bnm;
   logic s1, s2;
   logic [OW-1:0] f_an, f_ad, f_bn, f_bd;

   assign f_an = OW'(req_tdata[15:0]);
   assign f_ad = OW'(req_tdata[31:16]);
   assign f_bn = OW'(req_tdata[47:32]);
   assign f_bd = OW'(req_tdata[63:48]);

   rau_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend(dv_a), .divisor(dv_b),
      .sts(dsts), .quotient(dq), .remainder(dr)
   );

   assign anm = an_ff[OW] ? OW'(-an_ff) : an_ff[OW-1:0];
   assign bnm = bn_ff[OW] ? OW'(-bn_ff) : bn_ff[OW-1:0];
   assign lhs = an_ff * bd_ff;
   assign rhs = bn_ff * ad_ff;
   assign s1 = an_ff[OW];
   assign s2 = bn_ff[OW] ^ (op_ff == OP_SUB);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (req_tvalid) st_in = ST_SIGN;
         ST_SIGN:  begin
            if (err_ff || op_ff > OP_LT || ad_ff == '0 || bd_ff == '0) st_in = ST_OUT;
            else if (op_ff == OP_GT || op_ff == OP_LT) st_in = ST_OUT;
            else if (op_ff == OP_ADD || op_ff == OP_SUB) st_in = ST_GCD1;
            else st_in = ST_MUL;
         end
         ST_MUL:   st_in = (op_ff == OP_DIV && bn_ff == '0) ? ST_OUT : ST_GCD2;
         ST_GCD1:  if (dsts.done) st_in = (dr == '0) ? ST_LCM : ST_GCD1;
         ST_LCM:   if (dsts.done) st_in = ST_TERMS;
         ST_TERMS: if (dsts.done && sub_ff == 2'd1) st_in = ST_COMB;
         ST_COMB:  st_in = ST_GCD2;
         ST_GCD2:  if (y_ff == '0 || (dsts.done && dr == '0)) st_in = ST_RED;
         ST_RED:   if (dsts.done && sub_ff == 2'd1) st_in = ST_CHECK;
         ST_CHECK: st_in = ST_OUT;
         ST_OUT:   if (rsp_tvalid && rsp_tready) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in = op_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      x_in = x_ff; y_in = y_ff; n_in = n_ff; d_in = d_ff; t1_in = t1_ff;
      neg_in = neg_ff; err_in = err_ff; sub_in = sub_ff;
      onum_in = onum_ff; oden_in = oden_ff;
      dctl.start = 1'b0; dv_a = x_ff; dv_b = y_ff;
      unique case (st_ff)
         ST_IDLE: begin
            op_in = req_tuser;
            an_in = (OW+1)'($signed(f_an)); ad_in = (OW+1)'($signed(f_ad));
            bn_in = (OW+1)'($signed(f_bn)); bd_in = (OW+1)'($signed(f_bd));
            err_in = 1'b0; onum_in = '0; oden_in = '0;
         end
         ST_SIGN: begin
            if (op_ff > OP_LT || ad_ff == '0 || bd_ff == '0) err_in = 1'b1;
            if (ad_ff[OW]) begin ad_in = -ad_ff; an_in = -an_ff; end
            if (bd_ff[OW]) begin bd_in = -bd_ff; bn_in = -bn_ff; end
            x_in = W'(ad_in[OW-1:0]) | (W'(ad_in[OW]) << OW);
            y_in = W'(bd_in[OW-1:0]) | (W'(bd_in[OW]) << OW);
            dctl.start = (st_in == ST_GCD1);
            dv_a = x_in; dv_b = y_in;
         end
         ST_MUL: begin
            if (op_ff == OP_DIV) begin
               if (bn_ff == '0) err_in = 1'b1;
               n_in = W'(anm) * W'(bd_ff[OW-1:0]);
               d_in = W'(ad_ff[OW-1:0]) * W'(bnm);
               neg_in = an_ff[OW] ^ bn_ff[OW];
            end else begin
               n_in = W'(anm) * W'(bnm);
               d_in = W'(ad_ff[OW-1:0]) * W'(bd_ff[OW-1:0]);
               neg_in = an_ff[OW] ^ bn_ff[OW];
            end
            x_in = n_in; y_in = d_in;
            if (n_in == '0) neg_in = 1'b0;
            dctl.start = (y_in != '0);
            dv_a = x_in; dv_b = y_in;
         end
         ST_GCD1: if (dsts.done) begin
            x_in = y_ff; y_in = dr;
            dctl.start = 1'b1;
            if (dr == '0) begin
               // lcm: ad / g
               dv_a = W'(ad_ff[OW-1:0]); dv_b = y_ff;
            end else begin
               dv_a = y_ff; dv_b = dr;
            end
         end
         ST_LCM: if (dsts.done) begin
            d_in = W'(dq[OW:0]) * W'(bd_ff[OW-1:0]);
            dctl.start = 1'b1; sub_in = 2'd0;
            dv_a = d_in; dv_b = W'(ad_ff[OW-1:0]);
         end
         ST_TERMS: if (dsts.done) begin
            if (sub_ff == 2'd0) begin
               t1_in = W'(dq[OW:0]) * W'(anm);
               sub_in = 2'd1; dctl.start = 1'b1;
               dv_a = d_ff; dv_b = W'(bd_ff[OW-1:0]);
            end else begin
               x_in = W'(dq[OW:0]) * W'(bnm);
            end
         end
         ST_COMB: begin
            if (s1 == s2) begin n_in = t1_ff + x_ff; neg_in = s1; end
            else if (t1_ff >= x_ff) begin n_in = t1_ff - x_ff; neg_in = s1; end
            else begin n_in = x_ff - t1_ff; neg_in = s2; end
            if (n_in == '0) neg_in = 1'b0;
            x_in = n_in; y_in = d_ff;
            dctl.start = 1'b1; dv_a = x_in; dv_b = y_in;
         end
         ST_GCD2: begin
            if (y_ff == '0) begin
               // gcd is x: reduce numerator first
               dctl.start = 1'b1; dv_a = n_ff; dv_b = x_ff; sub_in = 2'd0; y_in = x_ff;
            end else if (dsts.done) begin
               x_in = y_ff; y_in = dr;
               if (dr != '0) begin
                  dctl.start = 1'b1; dv_a = y_ff; dv_b = dr;
               end else begin
                  dctl.start = 1'b1; dv_a = n_ff; dv_b = y_ff; sub_in = 2'd0;
                  y_in = y_ff;
               end
            end
         end
         ST_RED: if (dsts.done) begin
            if (sub_ff == 2'd0) begin
               n_in = dq; sub_in = 2'd1; dctl.start = 1'b1;
               dv_a = d_ff; dv_b = y_ff;
            end else begin
               d_in = dq;
            end
         end
         ST_CHECK: begin
            if (d_ff == '0 || d_ff > W'(32'h7FFF_FFFF) ||
                (neg_ff ? n_ff > W'(32'h8000_0000) : n_ff > W'(32'h7FFF_FFFF))) begin
               err_in = 1'b1;
            end else begin
               onum_in = neg_ff ? 32'(-n_ff) : n_ff[31:0];
               oden_in = d_ff[30:0];
            end
         end
         default: ;
      endcase
   end

   // compare is resolved in the first output cycle
   logic cmp_now;
   assign cmp_now = (op_ff == OP_GT) ? (lhs > rhs) : (lhs < rhs);

   always_ff @(posedge clock) begin
      op_ff <= op_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      x_ff <= x_in; y_ff <= y_in; n_ff <= n_in; d_ff <= d_in; t1_ff <= t1_in;
      neg_ff <= neg_in; err_ff <= err_in; sub_ff <= sub_in;
      onum_ff <= onum_in; oden_ff <= oden_in;
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   // compare flag evaluated after sign fix, held in a small side register
   logic cmpv_ff;
   always_ff @(posedge clock) begin
      if (st_ff == ST_SIGN) cmpv_ff <= 1'b0;
      else if (st_ff == ST_OUT && !cmpv_ff) cmpv_ff <= 1'b1;
   end
   logic cmp_res_ff;
   always_ff @(posedge clock) begin
      if (st_ff == ST_OUT && !cmpv_ff) cmp_res_ff <= cmp_now;
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_OUT) && cmpv_ff;
   assign rsp_tdata = {1'b0, err_ff ? 31'd0 : oden_ff, err_ff ? 32'd0 : onum_ff};
   assign rsp_tuser = {err_ff, !err_ff && (op_ff == OP_GT || op_ff == OP_LT) && cmp_res_ff};

   `RAU_ASSERT_IMPL(a_excl, rsp_tvalid, !req_tready)
   `RAU_ASSERT_NEXT(a_start, req_tvalid && req_tready, st_ff == ST_SIGN)
   `RAU_ASSERT_IMPL(a_errz, rsp_tvalid && rsp_tuser[1], rsp_tdata == '0)
endmodule
